>>> hdl/nth_smooth_number_generator_unit_defines.svh
// Assertion macros used by the checker of the smooth number unit.
// No dependencies; take this file in with `include before the macros are used.
`ifndef NTH_SMOOTH_NUMBER_GENERATOR_UNIT_DEFINES_SVH
`define NTH_SMOOTH_NUMBER_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define NSNG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NSNG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/nsng_pkg.sv
// Package for the 5-smooth number unit: sizes, state and select codes,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package nsng_pkg;

   localparam int MAX_N  = 1024;
   localparam int IDX_W  = 11;
   localparam int ADDR_W = $clog2(MAX_N);
   localparam int VAL_W  = 32;
   localparam int CAND_W = VAL_W + 3;   // room for x5

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD2,
      ST_RD3,
      ST_RD5,
      ST_CAND,
      ST_APPEND,
      ST_RESP
   } nsng_state_type;

   typedef enum logic [1:0] {
      RD_SEL_P2,
      RD_SEL_P3,
      RD_SEL_P5,
      RD_SEL_REQ
   } nsng_rd_sel_type;

   typedef struct packed {
      logic            latch_req;
      logic            rd_en;
      nsng_rd_sel_type rd_sel;
      logic            cap_v2;
      logic            cap_v3;
      logic            cap_cand;
      logic            seed;
      logic            append;
      logic            rsp_load;
   } nsng_cmd_type;

   typedef struct packed {
      logic req_zero;
      logic req_big;
      logic have_enough;
      logic table_empty;
   } nsng_status_type;

endpackage

`default_nettype wire

>>> hdl/nsng_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on nsng_pkg for the payload widths.
`default_nettype none

interface nsng_req_if;
   logic                        valid;
   logic                        ready;
   logic [nsng_pkg::IDX_W-1:0]  request_index;

   modport source (output valid, output request_index, input ready);
   modport sink   (input valid, input request_index, output ready);
endinterface

interface nsng_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [nsng_pkg::VAL_W-1:0]  smooth_value;
   logic                        index_too_large;

   modport source (output valid, output smooth_value, output index_too_large, input ready);
   modport sink   (input valid, input smooth_value, input index_too_large, output ready);
endinterface

`default_nettype wire

>>> hdl/nsng_datapath.sv
// Datapath: sequence table memory, x2/x3/x5 pointers, candidate registers,
// request and response registers. Depends on nsng_pkg.
`default_nettype none

module nsng_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire nsng_pkg::nsng_cmd_type     cmd,
   output nsng_pkg::nsng_status_type       status,
   input  wire logic [nsng_pkg::IDX_W-1:0] req_index,
   output logic [nsng_pkg::VAL_W-1:0]      smooth_value,
   output logic                            index_too_large
);

   logic [nsng_pkg::VAL_W-1:0]  mem [nsng_pkg::MAX_N];

   logic [nsng_pkg::IDX_W-1:0]  req_index_ff;
   logic [nsng_pkg::IDX_W-1:0]  filled_ff, filled_in;
   logic [nsng_pkg::IDX_W-1:0]  p2_ff, p2_in;
   logic [nsng_pkg::IDX_W-1:0]  p3_ff, p3_in;
   logic [nsng_pkg::IDX_W-1:0]  p5_ff, p5_in;
   logic [nsng_pkg::VAL_W-1:0]  rd_data_ff;
   logic [nsng_pkg::VAL_W-1:0]  v2_ff, v3_ff;
   logic [nsng_pkg::CAND_W-1:0] cand2_ff, cand3_ff, cand5_ff;
   logic [nsng_pkg::CAND_W-1:0] cand2_in, cand3_in, cand5_in;
   logic [nsng_pkg::CAND_W-1:0] min23, least;
   logic [nsng_pkg::VAL_W-1:0]  smooth_value_ff;
   logic                        too_large_ff;

   logic [nsng_pkg::IDX_W-1:0]  req_m1;
   logic [nsng_pkg::ADDR_W-1:0] rd_addr;
   logic [nsng_pkg::ADDR_W-1:0] wr_addr;
   logic [nsng_pkg::VAL_W-1:0]  wr_data;
   logic                        wr_en;

   assign req_m1 = req_index_ff - nsng_pkg::IDX_W'(1);

   assign status.req_zero    = (req_index_ff == '0);
   assign status.req_big     = (req_index_ff > nsng_pkg::IDX_W'(nsng_pkg::MAX_N));
   assign status.have_enough = (filled_ff >= req_index_ff);
   assign status.table_empty = (filled_ff == '0);

   always_comb begin
      unique case (cmd.rd_sel)
         nsng_pkg::RD_SEL_P2:  rd_addr = p2_ff[nsng_pkg::ADDR_W-1:0];
         nsng_pkg::RD_SEL_P3:  rd_addr = p3_ff[nsng_pkg::ADDR_W-1:0];
         nsng_pkg::RD_SEL_P5:  rd_addr = p5_ff[nsng_pkg::ADDR_W-1:0];
         nsng_pkg::RD_SEL_REQ: rd_addr = req_m1[nsng_pkg::ADDR_W-1:0];
         default:              rd_addr = '0;
      endcase
   end

   // candidates by shift and add; v5 comes straight off the read register
   assign cand2_in = {3'b000, v2_ff} << 1;
   assign cand3_in = {3'b000, v3_ff} + ({3'b000, v3_ff} << 1);
   assign cand5_in = {3'b000, rd_data_ff} + ({3'b000, rd_data_ff} << 2);

   assign min23 = (cand2_ff < cand3_ff) ? cand2_ff : cand3_ff;
   assign least = (cand5_ff < min23) ? cand5_ff : min23;

   always_comb begin
      wr_en   = cmd.seed || cmd.append;
      wr_addr = filled_ff[nsng_pkg::ADDR_W-1:0];
      wr_data = cmd.seed ? nsng_pkg::VAL_W'(1) : least[nsng_pkg::VAL_W-1:0];
      filled_in = filled_ff;
      p2_in     = p2_ff;
      p3_in     = p3_ff;
      p5_in     = p5_ff;
      if (wr_en) begin
         filled_in = filled_ff + nsng_pkg::IDX_W'(1);
      end
      if (cmd.append) begin
         // every pointer that produced the minimum steps, so duplicates drop out
         if (cand2_ff == least) p2_in = p2_ff + nsng_pkg::IDX_W'(1);
         if (cand3_ff == least) p3_in = p3_ff + nsng_pkg::IDX_W'(1);
         if (cand5_ff == least) p5_in = p5_ff + nsng_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         p2_ff     <= '0;
         p3_ff     <= '0;
         p5_ff     <= '0;
      end else begin
         filled_ff <= filled_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         p5_ff     <= p5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_index_ff <= req_index;
      if (cmd.cap_v2)    v2_ff        <= rd_data_ff;
      if (cmd.cap_v3)    v3_ff        <= rd_data_ff;
      if (cmd.cap_cand) begin
         cand2_ff <= cand2_in;
         cand3_ff <= cand3_in;
         cand5_ff <= cand5_in;
      end
      if (cmd.rsp_load) begin
         smooth_value_ff <= (status.req_zero || status.req_big) ? '0 : rd_data_ff;
         too_large_ff    <= status.req_big;
      end
   end

   assign smooth_value    = smooth_value_ff;
   assign index_too_large = too_large_ff;

endmodule

`default_nettype wire

>>> hdl/nsng_ctrl.sv
// Controller FSM: sequences table growth and lookup, owns the channel
// handshakes and the response valid flag. Depends on nsng_pkg.
`default_nettype none

module nsng_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire nsng_pkg::nsng_status_type status,
   output nsng_pkg::nsng_cmd_type         cmd
);

   nsng_pkg::nsng_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsng_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.latch_req = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.rd_sel    = nsng_pkg::RD_SEL_P2;
      cmd.cap_v2    = 1'b0;
      cmd.cap_v3    = 1'b0;
      cmd.cap_cand  = 1'b0;
      cmd.seed      = 1'b0;
      cmd.append    = 1'b0;
      cmd.rsp_load  = 1'b0;

      unique case (state_ff)
         nsng_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = nsng_pkg::ST_CHECK;
            end
         end
         nsng_pkg::ST_CHECK: begin
            priority if (status.req_zero || status.req_big) begin
               state_in = nsng_pkg::ST_RESP;
            end else if (status.have_enough) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = nsng_pkg::RD_SEL_REQ;
               state_in   = nsng_pkg::ST_RESP;
            end else if (status.table_empty) begin
               cmd.seed = 1'b1;   // first element is 1
            end else begin
               state_in = nsng_pkg::ST_RD2;
            end
         end
         nsng_pkg::ST_RD2: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = nsng_pkg::RD_SEL_P2;
            state_in   = nsng_pkg::ST_RD3;
         end
         nsng_pkg::ST_RD3: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = nsng_pkg::RD_SEL_P3;
            cmd.cap_v2 = 1'b1;
            state_in   = nsng_pkg::ST_RD5;
         end
         nsng_pkg::ST_RD5: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = nsng_pkg::RD_SEL_P5;
            cmd.cap_v3 = 1'b1;
            state_in   = nsng_pkg::ST_CAND;
         end
         nsng_pkg::ST_CAND: begin
            cmd.cap_cand = 1'b1;
            state_in     = nsng_pkg::ST_APPEND;
         end
         nsng_pkg::ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = nsng_pkg::ST_CHECK;
         end
         nsng_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = nsng_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nsng_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hdl/nth_smooth_number_generator_unit.sv
// Top level of the 5-smooth (Hamming) number unit.
// Depends on nsng_pkg, nsng_if, nsng_ctrl and nsng_datapath.
//
// req_if carries request_index n; rsp_if returns smooth_value, the n-th number
//   of the form 2^a*3^b*5^c counting from 1, and index_too_large. n = 0 answers
//   0; n above 1024 answers 0 with index_too_large set. One response per request.
// The sequence table is built on demand and kept across requests. Each new
//   element steps through a check, three reads of the single table port for
//   the x2, x3 and x5 operands, a state that forms candidates and one that writes.
// A request already covered by the table, index 0 or out of range: the check
//   state goes straight to the response state, which loads the output register,
//   sets response valid and returns to idle to take the next request.
// One request is worked on at a time; req_if.ready is high only when the
//   controller is idle.
// Reset (synchronous): pointers, fill count and response valid clear, so the
//   table is rebuilt from scratch. No clearing pass is needed.
// Stall: a finished response waits in the output register while the next
//   request is accepted and worked on; that response then waits for the drain.
`default_nettype none

module nth_smooth_number_generator_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   nsng_req_if.sink    req_if,
   nsng_rsp_if.source  rsp_if
);

   nsng_pkg::nsng_cmd_type    cmd;
   nsng_pkg::nsng_status_type status;

   nsng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nsng_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_index       (req_if.request_index),
      .smooth_value    (rsp_if.smooth_value),
      .index_too_large (rsp_if.index_too_large)
   );

endmodule

`default_nettype wire

>>> hdl/nsng_checker.sv
// Port-level checker for the smooth number unit, bound to the top level.
// Depends on nsng_pkg and nth_smooth_number_generator_unit_defines.svh.
`default_nettype none
`include "nth_smooth_number_generator_unit_defines.svh"

module nsng_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [nsng_pkg::VAL_W-1:0] rsp_smooth_value,
   input wire logic                       rsp_index_too_large
);

   logic       req_acc, rsp_acc;
   logic       rsp_stall, rsp_err;
   logic [nsng_pkg::VAL_W:0] rsp_payload;
   logic [1:0] pending_ff, pending_in;

   assign req_acc     = req_valid && req_ready;
   assign rsp_acc     = rsp_valid && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_err     = rsp_valid && rsp_index_too_large;
   assign rsp_payload = {rsp_smooth_value, rsp_index_too_large};

   // items accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) pending_in = pending_ff + 2'd1;
      if (rsp_acc && !req_acc) pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `NSNG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "valid dropped in stall")
   `NSNG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_payload), "payload moved")
   `NSNG_ASSERT_NOW(a_err_zero, clock, reset, rsp_err, rsp_smooth_value == '0, "value on error")
   `NSNG_ASSERT_NOW(a_no_orphan, clock, reset, rsp_valid, pending_ff != 2'd0, "orphan response")
   `NSNG_ASSERT_NOW(a_depth, clock, reset, 1'b1, pending_ff != 2'd3, "too many outstanding")

endmodule

bind nth_smooth_number_generator_unit nsng_checker u_nsng_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_smooth_value    (rsp_if.smooth_value),
   .rsp_index_too_large (rsp_if.index_too_large)
);

`default_nettype wire

>>> tb/sv/tb_nth_smooth_number_generator_unit.sv
// Testbench for nth_smooth_number_generator_unit: drives request items, predicts
// each 5-smooth result with its own on-demand sequence builder and checks responses.
// Depends on nsng_pkg, nsng_if and the RTL of the unit.
`default_nettype none

module tb_nth_smooth_number_generator_unit;

   localparam int RANDOM_ITEMS = 560;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int IDX_MAX      = (1 << nsng_pkg::IDX_W) - 1;

   typedef struct packed {
      logic [nsng_pkg::VAL_W-1:0] value;
      logic                       too_large;
   } smooth_result_type;

   class smooth_scoreboard_type;
      logic [nsng_pkg::VAL_W-1:0] hamming_seq [nsng_pkg::MAX_N];
      int unsigned                built, ptr2, ptr3, ptr5;
      smooth_result_type          awaited[$];
      int unsigned                mismatches, matched, zero_reqs, big_reqs;

      // one more element: least of the three products, every equal pointer moves on
      function void extend_sequence();
         logic [nsng_pkg::CAND_W-1:0] c2, c3, c5, least;
         if (built == 0) begin
            hamming_seq[0] = 1;
            built = 1;
            return;
         end
         c2 = {3'b000, hamming_seq[ptr2]} * 2;
         c3 = {3'b000, hamming_seq[ptr3]} * 3;
         c5 = {3'b000, hamming_seq[ptr5]} * 5;
         least = (c2 < c3) ? c2 : c3;
         if (c5 < least) least = c5;
         hamming_seq[built] = least[nsng_pkg::VAL_W-1:0];
         if (c2 == least) ptr2++;
         if (c3 == least) ptr3++;
         if (c5 == least) ptr5++;
         built++;
      endfunction

      function void note_request(logic [nsng_pkg::IDX_W-1:0] n);
         smooth_result_type want;
         want = '0;
         if (n == 0) begin
            zero_reqs++;
         end else if (n > nsng_pkg::MAX_N) begin
            want.too_large = 1'b1;
            big_reqs++;
         end else begin
            while (built < n) extend_sequence();
            want.value = hamming_seq[n - 1];
         end
         awaited = {awaited, want};
      endfunction

      function void check_result(logic [nsng_pkg::VAL_W-1:0] value, logic too_large);
         smooth_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: result with no request pending: value=%0d too_large=%b",
                     $time, value, too_large);
            return;
         end
         want = awaited.pop_front();
         if (value !== want.value || too_large !== want.too_large) begin
            mismatches++;
            if (value !== want.value)
               $display("%0t: smooth_value expected %0d got %0d",
                        $time, want.value, value);
            if (too_large !== want.too_large)
               $display("%0t: index_too_large expected %b got %b",
                        $time, want.too_large, too_large);
         end else begin
            matched++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   nsng_req_if req_if ();
   nsng_rsp_if rsp_if ();

   nth_smooth_number_generator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   smooth_scoreboard_type sb = new;

   int unsigned results_seen = 0;
   int unsigned cycle_count  = 0;
   int unsigned requests_sent = 0;
   bit          send_steady = 1'b0;

   // growth one step at a time first, then the special indexes and bit patterns
   logic [nsng_pkg::IDX_W-1:0] directed_idx [20] = '{
      1, 0, 2, 3, 4, 5, 6, 7, 8, 9,
      1025, 2047, 1690, 1365, 0, 12, 5, 1, 60, 85
   };

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("FAIL nth_smooth_number_generator_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         sb.check_result(rsp_if.smooth_value, rsp_if.index_too_large);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // zero, out of range, already built or just past the built part, so the table grows in uneven steps
   function automatic logic [nsng_pkg::IDX_W-1:0] random_index();
      int r;
      int unsigned top;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 18) return nsng_pkg::IDX_W'($urandom_range(nsng_pkg::MAX_N + 1, IDX_MAX));
      if (r < 55 && sb.built < nsng_pkg::MAX_N) begin
         top = sb.built + $urandom_range(1, 30);
         return nsng_pkg::IDX_W'((top > nsng_pkg::MAX_N) ? nsng_pkg::MAX_N : top);
      end
      return nsng_pkg::IDX_W'($urandom_range(1, (sb.built == 0) ? 1 : sb.built));
   endfunction

   // entered and left at a falling edge
   task automatic send_request(input logic [nsng_pkg::IDX_W-1:0] idx);
      int gap;
      if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
      gap = send_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.request_index <= idx;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(idx);
      requests_sent++;
      @(negedge clock);
   endtask

   // response side: random stalls, steady stretches, one long hold-off
   initial begin
      int stall_left;
      bit squeezed;
      bit steady;
      stall_left   = 0;
      squeezed     = 1'b0;
      steady       = 1'b0;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!squeezed && results_seen >= 150) begin
            squeezed   = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if ($urandom_range(0, 39) == 0) steady = !steady;
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!steady) stall_left = pick_gap();
         end
      end
   end

   initial begin
      req_if.valid         = 1'b0;
      req_if.request_index = '0;
      reset                = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_idx[i]) send_request(directed_idx[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) send_request(random_index());
      req_if.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d index zero, %0d out of range), %0d results",
               requests_sent, sb.zero_reqs, sb.big_reqs, results_seen);
      $display("sequence grown to %0d entries, response side held off %0d cycles once",
               sb.built, HOLD_CYCLES);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS nth_smooth_number_generator_unit");
      end else begin
         $display("FAIL nth_smooth_number_generator_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> nth_smooth_number_generator_unit.f
+incdir+hdl
hdl/nsng_pkg.sv
hdl/nsng_if.sv
hdl/nsng_datapath.sv
hdl/nsng_ctrl.sv
hdl/nth_smooth_number_generator_unit.sv
hdl/nsng_checker.sv
tb/sv/tb_nth_smooth_number_generator_unit.sv
